// File: hw/rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and helper functions for the barometric
// temperature and pressure compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned FrontStages = 12;
  localparam int unsigned DivStages   = 32;

  localparam logic [31:0] TempMax     = 32'sd2097151;
  localparam logic [31:0] TempMin     = -32'sd2097152;
  localparam logic [31:0] PressMax    = 32'd1048575;
  localparam logic [31:0] TempRound   = 32'd128;
  localparam logic [31:0] PressOffset = 32'd64000;
  localparam logic [31:0] PressBase   = 32'd1048576;
  localparam logic [31:0] PressScale  = 32'd3125;
  localparam logic [31:0] DivOneQ15   = 32'd32768;

  typedef enum logic [2:0] {
    CFG_TEMP_CALIB  = 3'd0,
    CFG_PRESS_A     = 3'd1,
    CFG_PRESS_B     = 3'd2,
    CFG_PRESS_P9    = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [21:0] tc;
    logic        err;
    logic        post;
  } side_t;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(logic [31:0] x, int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

endpackage

// File: hw/rtl/bpc_if.sv
// ----------------------------------------------------------------------------
// bpc_in_if / bpc_out_if
// Valid/ready channels carrying raw sample words and compensated result words.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;

  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [21:0] temperature_centi;
  logic        [19:0] pressure_pa;
  logic               divide_error;

  modport source (output valid, temperature_centi, pressure_pa, divide_error,
                  input ready);
  modport sink   (input valid, temperature_centi, pressure_pa, divide_error,
                  output ready);
endinterface

// File: hw/rtl/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front
// Twelve-stage front end: fine temperature, temperature output and the
// pressure dividend and divisor.
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [19:0]           raw_t_i,
  input  logic [19:0]           raw_p_i,
  input  logic [47:0]           calib_t_i,
  input  logic [63:0]           calib_a_i,
  input  logic [15:0]           calib_p5_i,
  input  logic [15:0]           calib_p6_i,
  output logic                  valid_o,
  output logic [31:0]           dvd_o,
  output logic [31:0]           dsr_o,
  output bpc_pkg::side_t        side_o
);

  logic [bpc_pkg::FrontStages-1:0] vld_q;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
  assign t1 = {16'b0, calib_t_i[15:0]};
  assign t2 = bpc_pkg::sx16(calib_t_i[31:16]);
  assign t3 = bpc_pkg::sx16(calib_t_i[47:32]);
  assign p1 = {16'b0, calib_a_i[15:0]};
  assign p2 = bpc_pkg::sx16(calib_a_i[31:16]);
  assign p3 = bpc_pkg::sx16(calib_a_i[47:32]);
  assign p4 = bpc_pkg::sx16(calib_a_i[63:48]);
  assign p5 = bpc_pkg::sx16(calib_p5_i);
  assign p6 = bpc_pkg::sx16(calib_p6_i);

  logic [31:0] d1_q, d2_q, m1_q, m2_q, v1_q, x_q, tfine_q;
  logic [31:0] a5_q, q5_q, sq6_q, pa5_6_q, pa2_6_q;
  logic [31:0] b6_q, c3_q, pa5_7_q, pa2_7_q, b8_q, a18_q, a1_q, b9_q;
  logic [31:0] dsr10_q, pnum_q, dsr11_q, p11_q, dvd_q, dsr_q;
  logic [21:0] tc5_q, tc6_q, tc7_q, tc8_q, tc9_q, tc10_q, tc11_q, tc12_q;
  logic [19:0] ap1_q, ap2_q, ap3_q, ap4_q, ap5_q, ap6_q, ap7_q, ap8_q, ap9_q;
  logic        err_q, post_q;

  logic [31:0] tw5, a5, b8, pnum;
  logic [21:0] tc5;

  always_comb begin
    tw5 = bpc_pkg::asr((tfine_q << 2) + tfine_q + bpc_pkg::TempRound, 8);
    if ($signed(tw5) > $signed(bpc_pkg::TempMax)) begin
      tc5 = bpc_pkg::TempMax[21:0];
    end else if ($signed(tw5) < $signed(bpc_pkg::TempMin)) begin
      tc5 = bpc_pkg::TempMin[21:0];
    end else begin
      tc5 = tw5[21:0];
    end
    a5   = bpc_pkg::asr(tfine_q, 1) - bpc_pkg::PressOffset;
    b8   = bpc_pkg::asr(bpc_pkg::asr(b6_q, 0) + (pa5_7_q << 1), 2) + (p4 << 16);
    pnum = (bpc_pkg::PressBase - {12'b0, ap9_q}) - bpc_pkg::asr(b9_q, 12);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[bpc_pkg::FrontStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q    <= {15'b0, raw_t_i[19:3]} - (t1 << 1);
      d2_q    <= {16'b0, raw_t_i[19:4]} - t1;
      ap1_q   <= raw_p_i;
      m1_q    <= d1_q * t2;
      m2_q    <= d2_q * d2_q;
      ap2_q   <= ap1_q;
      v1_q    <= bpc_pkg::asr(m1_q, 11);
      x_q     <= bpc_pkg::asr(m2_q, 12) * t3;
      ap3_q   <= ap2_q;
      tfine_q <= v1_q + bpc_pkg::asr(x_q, 14);
      ap4_q   <= ap3_q;
      tc5_q   <= tc5;
      a5_q    <= a5;
      q5_q    <= bpc_pkg::asr(a5, 2);
      ap5_q   <= ap4_q;
      sq6_q   <= q5_q * q5_q;
      pa5_6_q <= a5_q * p5;
      pa2_6_q <= p2 * a5_q;
      tc6_q   <= tc5_q;
      ap6_q   <= ap5_q;
      b6_q    <= bpc_pkg::asr(sq6_q, 11) * p6;
      c3_q    <= p3 * bpc_pkg::asr(sq6_q, 13);
      pa5_7_q <= pa5_6_q;
      pa2_7_q <= pa2_6_q;
      tc7_q   <= tc6_q;
      ap7_q   <= ap6_q;
      b8_q    <= b8;
      a18_q   <= bpc_pkg::asr(bpc_pkg::asr(c3_q, 3) + bpc_pkg::asr(pa2_7_q, 1), 18);
      tc8_q   <= tc7_q;
      ap8_q   <= ap7_q;
      a1_q    <= (bpc_pkg::DivOneQ15 + a18_q) * p1;
      b9_q    <= b8_q;
      tc9_q   <= tc8_q;
      ap9_q   <= ap8_q;
      dsr10_q <= bpc_pkg::asr(a1_q, 15);
      pnum_q  <= pnum;
      tc10_q  <= tc9_q;
      p11_q   <= pnum_q * bpc_pkg::PressScale;
      dsr11_q <= dsr10_q;
      tc11_q  <= tc10_q;
      post_q  <= p11_q[31];
      dvd_q   <= p11_q[31] ? p11_q : (p11_q << 1);
      dsr_q   <= dsr11_q;
      err_q   <= (dsr11_q == '0);
      tc12_q  <= tc11_q;
    end
  end

  assign valid_o     = vld_q[bpc_pkg::FrontStages-1];
  assign dvd_o       = dvd_q;
  assign dsr_o       = dsr_q;
  assign side_o.tc   = tc12_q;
  assign side_o.err  = err_q;
  assign side_o.post = post_q;

endmodule

// File: hw/rtl/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [31:0]    dvd_i,
  input  logic [31:0]    dsr_i,
  input  bpc_pkg::side_t side_i,
  output logic           valid_o,
  output logic [31:0]    quo_o,
  output bpc_pkg::side_t side_o
);

  logic [bpc_pkg::DivStages-1:0] vld_q;
  logic [31:0]    rem_q  [bpc_pkg::DivStages];
  logic [31:0]    dvd_q  [bpc_pkg::DivStages];
  logic [31:0]    quo_q  [bpc_pkg::DivStages];
  logic [31:0]    dsr_q  [bpc_pkg::DivStages];
  bpc_pkg::side_t side_q [bpc_pkg::DivStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[bpc_pkg::DivStages-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < bpc_pkg::DivStages; k++) begin : g_stage
    logic [31:0]    rem_in, dvd_in, quo_in, dsr_in;
    bpc_pkg::side_t side_in;
    logic [32:0]    trial;
    logic           fits;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign dvd_in  = dvd_i;
      assign quo_in  = '0;
      assign dsr_in  = dsr_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign dvd_in  = dvd_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign dsr_in  = dsr_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, dvd_in[31]};
    assign fits  = (trial >= {1'b0, dsr_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= fits ? 32'(trial - {1'b0, dsr_in}) : trial[31:0];
        dvd_q[k]  <= dvd_in << 1;
        quo_q[k]  <= {quo_in[30:0], fits};
        dsr_q[k]  <= dsr_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[bpc_pkg::DivStages-1];
  assign quo_o   = quo_q[bpc_pkg::DivStages-1];
  assign side_o  = side_q[bpc_pkg::DivStages-1];

endmodule

// File: hw/rtl/bpc_back.sv
// ----------------------------------------------------------------------------
// bpc_back
// Two-stage pressure correction after the divide, with saturation and
// zero-divisor handling.
// ----------------------------------------------------------------------------
module bpc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [31:0]    quo_i,
  input  bpc_pkg::side_t side_i,
  input  logic [15:0]    calib_p7_i,
  input  logic [15:0]    calib_p8_i,
  input  logic [15:0]    calib_p9_i,
  output logic           valid_o,
  output logic [21:0]    tc_o,
  output logic [19:0]    pa_o,
  output logic           err_o
);

  logic [1:0]     vld_q;
  logic [31:0]    pa_q, sqp_q, m8_q, pb_q, v1_q, v2_q;
  bpc_pkg::side_t sa_q, sb_q;
  logic [31:0]    p, pf;

  assign p = side_i.post ? {quo_i[30:0], 1'b0} : quo_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q  <= p;
      sqp_q <= {3'b0, p[31:3]} * {3'b0, p[31:3]};
      m8_q  <= {2'b0, p[31:2]} * bpc_pkg::sx16(calib_p8_i);
      sa_q  <= side_i;
      pb_q  <= pa_q;
      v1_q  <= bpc_pkg::asr(bpc_pkg::sx16(calib_p9_i) * {13'b0, sqp_q[31:13]}, 12);
      v2_q  <= bpc_pkg::asr(m8_q, 13);
      sb_q  <= sa_q;
    end
  end

  assign pf      = pb_q + bpc_pkg::asr(v1_q + v2_q + bpc_pkg::sx16(calib_p7_i), 4);
  assign valid_o = vld_q[1];
  assign tc_o    = sb_q.tc;
  assign err_o   = sb_q.err;
  assign pa_o    = sb_q.err ? '0 : ((pf > bpc_pkg::PressMax) ? 20'hFFFFF : pf[19:0]);

endmodule

// File: hw/rtl/baro_temp_pressure_compensation.sv
// An accepted sample word passes through the front end, the divider, the back end and the output register.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds in place while the output register is full and not taken.
// The 32-stage restoring divider sets most of the latency.
// Reset (rst_ni low, asynchronous) clears all valid bits and the
// calibration registers to zero.
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation of raw barometric readings.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  bpc_in_if.sink      in_i,
  bpc_out_if.source   out_o
);

  logic [47:0] temp_calib_q;
  logic [63:0] press_a_q, press_b_q;
  logic [15:0] press_p9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q <= '0;
      press_a_q    <= '0;
      press_b_q    <= '0;
      press_p9_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (bpc_pkg::cfg_idx_e'(cfg_idx_i))
        bpc_pkg::CFG_TEMP_CALIB: temp_calib_q <= cfg_data_i[47:0];
        bpc_pkg::CFG_PRESS_A:    press_a_q    <= cfg_data_i;
        bpc_pkg::CFG_PRESS_B:    press_b_q    <= cfg_data_i;
        bpc_pkg::CFG_PRESS_P9:   press_p9_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic           en;
  logic           out_vld_q;
  logic           f_vld, d_vld, b_vld;
  logic [31:0]    f_dvd, f_dsr, d_quo;
  bpc_pkg::side_t f_side, d_side;
  logic [21:0]    b_tc;
  logic [19:0]    b_pa;
  logic           b_err;
  logic [21:0]    tc_q;
  logic [19:0]    pa_q;
  logic           err_q;

  assign en       = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  bpc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_i.valid),
    .raw_t_i    (in_i.raw_temperature),
    .raw_p_i    (in_i.raw_pressure),
    .calib_t_i  (temp_calib_q),
    .calib_a_i  (press_a_q),
    .calib_p5_i (press_b_q[15:0]),
    .calib_p6_i (press_b_q[31:16]),
    .valid_o    (f_vld),
    .dvd_o      (f_dvd),
    .dsr_o      (f_dsr),
    .side_o     (f_side)
  );

  bpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld),
    .dvd_i   (f_dvd),
    .dsr_i   (f_dsr),
    .side_i  (f_side),
    .valid_o (d_vld),
    .quo_o   (d_quo),
    .side_o  (d_side)
  );

  bpc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (d_vld),
    .quo_i      (d_quo),
    .side_i     (d_side),
    .calib_p7_i (press_b_q[47:32]),
    .calib_p8_i (press_b_q[63:48]),
    .calib_p9_i (press_p9_q),
    .valid_o    (b_vld),
    .tc_o       (b_tc),
    .pa_o       (b_pa),
    .err_o      (b_err)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= b_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tc_q  <= b_tc;
      pa_q  <= b_pa;
      err_q <= b_err;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.temperature_centi = tc_q;
  assign out_o.pressure_pa       = pa_q;
  assign out_o.divide_error      = err_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.divide_error |-> out_o.pressure_pa == '0)
    else $error("pressure word not zero on a divide error");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input stalled without a blocked output word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(d_vld) && $stable(f_vld) && $stable(b_vld))
    else $error("pipeline moved during a stall");
`endif

endmodule
